[rtl/core/q4dq_pkg.sv]
`timescale 1ns / 1ps
// q4dq_pkg: shared types and constants of the q4 block dequantizer
package q4dq_pkg;

   localparam int LANES       = 4;
   localparam int BLOCK_ELEMS = 32;
   localparam int RESULTS     = BLOCK_ELEMS / LANES;

   localparam logic CSR_INPUT_WIDTH = 1'b0;
   localparam logic CSR_ROW_COUNT   = 1'b1;

   localparam logic [16:0] INPUT_WIDTH_RESET = 17'd4096;
   localparam logic [16:0] ROW_COUNT_RESET   = 17'd4096;

   localparam logic [15:0] FP16_QNAN_BIT = 16'h0200;
   localparam logic [15:0] FP16_DEF_NAN  = 16'h7E00;
   localparam logic [14:0] FP16_INF_MAG  = 15'h7C00;

   // lane after decode and significand product
   typedef struct packed {
      logic        fixed;
      logic [15:0] fval;
      logic        sgn;
      logic [4:0]  ee;
      logic [14:0] big;
   } lane_s1_type;

   // lane after normalization and rounding decision
   typedef struct packed {
      logic              fixed;
      logic [15:0]       fval;
      logic              sgn;
      logic              sub;
      logic [9:0]        smant;
      logic signed [6:0] be;
      logic [11:0]       q;
      logic              inc;
   } lane_s2_type;

endpackage

[rtl/core/q4_block_dequant_fp16_top.sv]
`timescale 1ns / 1ps
// q4_block_dequant_fp16_top: q4_0 block to fp16 dequantizer
//
// one request beat carries a 32-element quant block (row, block number, fp16
// scale and 16 packed bytes); the block answers with eight response beats of
// four fp16 halves each, in element order, the eighth flagged by rsp_last.
// a block whose row is at or beyond row_count, or whose block number is at or
// beyond input_width/32, is taken and yields nothing. throughput is set by
// the single four-half response beat per cycle when rsp_ready allows; a new
// request is taken in the cycle the previous block issues its eighth beat, so
// blocks follow each other with no gap. the fp16 multiply runs in a 3-stage
// pipeline (product, normalize/round decision, round/pack) followed by the
// response register; the whole pipeline moves together and holds under rsp
// backpressure. csr writes (index 0 input_width, index 1 row_count) saturate
// to MAX_WIDTH and MAX_ROWS and must only happen while the block is idle.
module q4_block_dequant_fp16_top
   import q4dq_pkg::*;
#(
   parameter int MAX_WIDTH = 65536,
   parameter int MAX_ROWS  = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_row,
   input  logic [10:0] req_block_number,
   input  logic [15:0] req_scale,
   input  logic [63:0] req_quants_low,
   input  logic [63:0] req_quants_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_index,
   output logic [15:0] rsp_half0,
   output logic [15:0] rsp_half1,
   output logic [15:0] rsp_half2,
   output logic [15:0] rsp_half3,
   output logic [27:0] rsp_source_block,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   // configuration
   logic [16:0] width_ff, width_in;
   logic [16:0] rows_ff, rows_in;
   logic [11:0] nblk;
   logic [12:0] nsp;

   // block buffer
   logic         buf_v_ff, buf_v_in;
   logic [15:0]  buf_row_ff;
   logic [10:0]  buf_blk_ff;
   logic [15:0]  buf_scale_ff;
   logic [127:0] buf_q_ff;
   logic [2:0]   j_ff, j_in;
   logic         adv, issue, take, in_range, buf_done;

   // pipeline
   logic        s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic [32:0] s1_pw_ff;
   logic [28:0] s1_ps_ff;
   logic [10:0] s1_blk_ff;
   logic [2:0]  s1_j_ff;
   logic [31:0] s2_idx_ff, s3_idx_ff, rsp_idx_ff;
   logic [27:0] s2_src_ff, s3_src_ff, rsp_src_ff;
   logic        s1_last_ff, s2_last_ff, s3_last_ff, rsp_last_ff;
   lane_s1_type s1_ff [LANES];
   lane_s2_type s2_ff [LANES];
   logic [15:0] s3_h_ff [LANES];
   logic [15:0] rsp_h_ff [LANES];

   assign csr_ready = 1'b1;

   always_comb begin
      width_in = width_ff;
      rows_in  = rows_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUT_WIDTH: begin
               width_in = ({15'd0, csr_wdata} > 32'(MAX_WIDTH)) ?
                          17'(MAX_WIDTH) : csr_wdata;
            end
            CSR_ROW_COUNT: begin
               rows_in = ({15'd0, csr_wdata} > 32'(MAX_ROWS)) ?
                         17'(MAX_ROWS) : csr_wdata;
            end
            default: ;
         endcase
      end
   end

   assign nblk = width_ff[16:5];
   // padded block stride: one extra block when the count is a power of two or zero
   assign nsp  = ((nblk & (nblk - 12'd1)) == 12'd0) ? {1'b0, nblk} + 13'd1
                                                    : {1'b0, nblk};

   // whole pipeline moves when the response register is free
   assign adv      = !rsp_v_ff || rsp_ready;
   assign issue    = buf_v_ff && adv;
   assign buf_done = issue && (j_ff == 3'(RESULTS - 1));
   assign req_ready = !buf_v_ff || buf_done;
   assign take     = req_valid && req_ready;
   assign in_range = ({1'b0, req_row} < rows_ff) && ({1'b0, req_block_number} < nblk);

   always_comb begin
      buf_v_in = buf_v_ff;
      j_in     = j_ff;
      if (issue) begin
         j_in = j_ff + 3'd1;
      end
      if (buf_done) begin
         buf_v_in = 1'b0;
      end
      if (take && in_range) begin
         buf_v_in = 1'b1;
         j_in     = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= INPUT_WIDTH_RESET;
         rows_ff  <= ROW_COUNT_RESET;
         buf_v_ff <= 1'b0;
         j_ff     <= 3'd0;
      end else begin
         width_ff <= width_in;
         rows_ff  <= rows_in;
         buf_v_ff <= buf_v_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_range) begin
         buf_row_ff   <= req_row;
         buf_blk_ff   <= req_block_number;
         buf_scale_ff <= req_scale;
         buf_q_ff     <= {req_quants_high, req_quants_low};
      end
   end

   // stage 1: nibble pick, sign, significand times |nibble-8|, index products
   lane_s1_type s1_in [LANES];
   always_comb begin
      logic [4:0]  e;
      logic [7:0]  bt;
      logic [3:0]  nib;
      logic [3:0]  mag;
      logic        neg;
      logic [4:0]  ex;
      logic [9:0]  mant;
      logic [10:0] sig;
      for (int l = 0; l < LANES; l++) begin
         e    = {j_ff, 2'(l)};
         bt   = buf_q_ff[{e[3:0], 3'b000} +: 8];
         nib  = e[4] ? bt[7:4] : bt[3:0];
         neg  = !nib[3];
         mag  = nib[3] ? {1'b0, nib[2:0]} : 4'd8 - nib;
         ex   = buf_scale_ff[14:10];
         mant = buf_scale_ff[9:0];
         sig  = (ex == 5'd0) ? {1'b0, mant} : {1'b1, mant};
         s1_in[l].sgn   = buf_scale_ff[15] ^ neg;
         s1_in[l].ee    = (ex == 5'd0) ? 5'd1 : ex;
         s1_in[l].big   = 15'(sig * mag);
         s1_in[l].fixed = 1'b0;
         s1_in[l].fval  = 16'd0;
         if (ex == 5'h1F) begin
            s1_in[l].fixed = 1'b1;
            if (mant != 10'd0) begin
               s1_in[l].fval = buf_scale_ff | FP16_QNAN_BIT;
            end else if (mag == 4'd0) begin
               s1_in[l].fval = FP16_DEF_NAN;
            end else begin
               s1_in[l].fval = {buf_scale_ff[15] ^ neg, FP16_INF_MAG};
            end
         end else if (sig == 11'd0 || mag == 4'd0) begin
            s1_in[l].fixed = 1'b1;
            s1_in[l].fval  = {buf_scale_ff[15] ^ neg, 15'd0};
         end
      end
   end

   // stage 2: leading one, exponent, subnormal field, rounding decision
   lane_s2_type s2_in [LANES];
   always_comb begin
      logic [3:0]  p;
      logic [3:0]  rb;
      logic [31:0] sh;
      logic [14:0] rem;
      logic [14:0] hlf;
      logic [14:0] qt;
      for (int l = 0; l < LANES; l++) begin
         p = 4'd0;
         for (int i = 0; i < 15; i++) begin
            if (s1_ff[l].big[i]) begin
               p = 4'(i);
            end
         end
         s2_in[l].fixed = s1_ff[l].fixed;
         s2_in[l].fval  = s1_ff[l].fval;
         s2_in[l].sgn   = s1_ff[l].sgn;
         s2_in[l].be    = $signed({3'd0, p}) + $signed({2'd0, s1_ff[l].ee}) - 7'sd10;
         s2_in[l].sub   = (s2_in[l].be <= 7'sd0);
         sh             = {17'd0, s1_ff[l].big} << (s1_ff[l].ee - 5'd1);
         s2_in[l].smant = sh[9:0];
         rb  = 4'd0;
         rem = 15'd0;
         hlf = 15'd0;
         qt  = 15'd0;
         s2_in[l].inc = 1'b0;
         if (p > 4'd10) begin
            rb  = p - 4'd10;
            qt  = s1_ff[l].big >> rb;
            rem = s1_ff[l].big & ((15'd1 << rb) - 15'd1);
            hlf = 15'd1 << (rb - 4'd1);
            s2_in[l].inc = (rem > hlf) || ((rem == hlf) && qt[0]);
         end else begin
            qt = s1_ff[l].big << (4'd10 - p);
         end
         s2_in[l].q = qt[11:0];
      end
   end

   // stage 3: apply rounding, carry into exponent, overflow, pack
   logic [15:0] s3_in [LANES];
   always_comb begin
      logic [11:0]       qf;
      logic signed [6:0] ben;
      for (int l = 0; l < LANES; l++) begin
         qf  = s2_ff[l].q + {11'd0, s2_ff[l].inc};
         ben = s2_ff[l].be;
         if (qf[11]) begin
            qf  = 12'd1024;
            ben = ben + 7'sd1;
         end
         if (s2_ff[l].fixed) begin
            s3_in[l] = s2_ff[l].fval;
         end else if (s2_ff[l].sub) begin
            s3_in[l] = {s2_ff[l].sgn, 5'd0, s2_ff[l].smant};
         end else if (ben >= 7'sd31) begin
            s3_in[l] = {s2_ff[l].sgn, FP16_INF_MAG};
         end else begin
            s3_in[l] = {s2_ff[l].sgn, ben[4:0], qf[9:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= issue;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pw_ff   <= 33'(buf_row_ff * width_ff);
         s1_ps_ff   <= 29'(buf_row_ff * nsp);
         s1_blk_ff  <= buf_blk_ff;
         s1_j_ff    <= j_ff;
         s1_last_ff <= (j_ff == 3'(RESULTS - 1));
         s2_idx_ff  <= s1_pw_ff[31:0] + {16'd0, s1_blk_ff, 5'd0} + {27'd0, s1_j_ff, 2'd0};
         s2_src_ff  <= s1_ps_ff[27:0] + {17'd0, s1_blk_ff};
         s2_last_ff <= s1_last_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_src_ff  <= s2_src_ff;
         s3_last_ff <= s2_last_ff;
         rsp_idx_ff <= s3_idx_ff;
         rsp_src_ff <= s3_src_ff;
         rsp_last_ff <= s3_last_ff;
         for (int l = 0; l < LANES; l++) begin
            s1_ff[l]    <= s1_in[l];
            s2_ff[l]    <= s2_in[l];
            s3_h_ff[l]  <= s3_in[l];
            rsp_h_ff[l] <= s3_h_ff[l];
         end
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_out_index    = rsp_idx_ff;
   assign rsp_half0        = rsp_h_ff[0];
   assign rsp_half1        = rsp_h_ff[1];
   assign rsp_half2        = rsp_h_ff[2];
   assign rsp_half3        = rsp_h_ff[3];
   assign rsp_source_block = rsp_src_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   // a new block is only taken over a busy buffer on its final beat
   a_ready_on_final: assert property (@(posedge clock) disable iff (reset)
      (req_ready && buf_v_ff) |-> (j_ff == 3'(RESULTS - 1)))
      else $error("request taken while block beats remain");

   // beat counter rests at zero whenever the buffer is empty
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !buf_v_ff |-> (j_ff == 3'd0))
      else $error("beat counter not cleared with empty buffer");

   // buffer only drains after issuing its eighth beat
   a_drain_full: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(buf_v_ff)) |-> $past(buf_done))
      else $error("block buffer emptied early");
`endif

endmodule
